// ===== rtl/core/global_timer_64bit_compare_macros.svh =====
// assertion macros for the global timer block
`ifndef GLOBAL_TIMER_64BIT_COMPARE_MACROS_SVH
`define GLOBAL_TIMER_64BIT_COMPARE_MACROS_SVH

// same-cycle implication, disabled during reset
`define GT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gt64c_pkg.sv =====
// types and constants shared by the global timer files
`timescale 1ns / 1ps
`default_nettype none

package gt64c_pkg;

    localparam int CmdWidth  = 2;
    localparam int SelWidth  = 3;
    localparam int DataWidth = 32;

    // transaction commands
    typedef enum logic [CmdWidth-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    // dense register map
    typedef enum logic [SelWidth-1:0] {
        REG_COUNT_LO = 3'd0,
        REG_COUNT_HI = 3'd1,
        REG_CONTROL  = 3'd2,
        REG_STATUS   = 3'd3,
        REG_COMP_LO  = 3'd4,
        REG_COMP_HI  = 3'd5,
        REG_AUTOINC  = 3'd6
    } reg_sel_t;

    // control register bits
    localparam int CTL_ENABLE_BIT  = 0;
    localparam int CTL_COMP_BIT    = 1;
    localparam int CTL_IRQ_BIT     = 2;
    localparam int CTL_AUTOINC_BIT = 3;
    localparam int PRESCALE_LSB    = 8;

    // architectural timer state
    typedef struct packed {
        logic [63:0] counter;
        logic [63:0] comparator;
        logic [31:0] increment;
        logic [3:0]  ctl;
        logic [7:0]  prescale;
        logic [7:0]  pcount;
        logic        flag;
    } timer_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/gt64c_if.sv =====
// request and response channel interfaces of the global timer
`timescale 1ns / 1ps
`default_nettype none

interface gt64c_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [2:0]  reg_sel;
    logic [31:0] wdata;

    modport source (output valid, output cmd, output reg_sel, output wdata, input ready);
    modport sink   (input valid, input cmd, input reg_sel, input wdata, output ready);
endinterface

interface gt64c_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] rdata;
    logic        irq;

    modport source (output valid, output rdata, output irq, input ready);
    modport sink   (input valid, input rdata, input irq, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gt64c_step.sv =====
// next-state and read-data logic for one timer transaction
`timescale 1ns / 1ps
`default_nettype none

module gt64c_step (
    input  gt64c_pkg::timer_state_t cur,
    input  logic [1:0]              cmd,
    input  logic [2:0]              reg_sel,
    input  logic [31:0]             wdata,
    output gt64c_pkg::timer_state_t nxt,
    output logic [31:0]             rdata,
    output logic                    irq
);
    import gt64c_pkg::*;

    logic [63:0] count_inc;
    logic [63:0] comp_inc;

    // counter and comparator adders run in parallel
    assign count_inc = cur.counter + 64'd1;
    assign comp_inc  = cur.comparator + {32'd0, cur.increment};

    always_comb
    begin
        nxt   = cur;
        rdata = '0;
        case (cmd_t'(cmd))
            CMD_TICK:
            begin
                if (cur.ctl[CTL_ENABLE_BIT])
                begin
                    if (cur.pcount >= cur.prescale)
                    begin
                        // prescaler expired: advance and compare against new count
                        nxt.pcount  = '0;
                        nxt.counter = count_inc;
                        if (cur.ctl[CTL_COMP_BIT] && (count_inc == cur.comparator))
                        begin
                            nxt.flag = 1'b1;
                            if (cur.ctl[CTL_AUTOINC_BIT])
                            begin
                                nxt.comparator = comp_inc;
                            end
                        end
                    end
                    else
                    begin
                        nxt.pcount = cur.pcount + 8'd1;
                    end
                end
            end
            CMD_READ:
            begin
                case (reg_sel_t'(reg_sel))
                    REG_COUNT_LO: rdata = cur.counter[31:0];
                    REG_COUNT_HI: rdata = cur.counter[63:32];
                    REG_CONTROL:  rdata = {16'd0, cur.prescale, 4'd0, cur.ctl};
                    REG_STATUS:   rdata = {31'd0, cur.flag};
                    REG_COMP_LO:  rdata = cur.comparator[31:0];
                    REG_COMP_HI:  rdata = cur.comparator[63:32];
                    REG_AUTOINC:  rdata = cur.increment;
                    default:      rdata = '0;
                endcase
            end
            CMD_WRITE:
            begin
                case (reg_sel_t'(reg_sel))
                    REG_COUNT_LO: nxt.counter[31:0]     = wdata;
                    REG_COUNT_HI: nxt.counter[63:32]    = wdata;
                    REG_CONTROL:
                    begin
                        nxt.ctl      = wdata[3:0];
                        nxt.prescale = wdata[PRESCALE_LSB +: 8];
                    end
                    REG_STATUS:
                    begin
                        // write one to clear
                        if (wdata[0])
                        begin
                            nxt.flag = 1'b0;
                        end
                    end
                    REG_COMP_LO:  nxt.comparator[31:0]  = wdata;
                    REG_COMP_HI:  nxt.comparator[63:32] = wdata;
                    REG_AUTOINC:  nxt.increment         = wdata;
                    default:      nxt = cur;
                endcase
            end
            default:
            begin
                nxt   = cur;
                rdata = '0;
            end
        endcase
    end

    // interrupt line after this transaction's update
    assign irq = nxt.flag & nxt.ctl[CTL_IRQ_BIT];

endmodule

`default_nettype wire

// ===== rtl/core/global_timer_64bit_compare.sv =====
// global timer: 64-bit prescaled counter with comparator and auto-increment
// the response is registered and appears in the cycle after the request is accepted
// throughput: one transaction per cycle while responses are taken, set by the single state register stage
// the output register frees on the same cycle the response is taken
// reset: asynchronous, clears all timer state, timer disabled, no response pending
`timescale 1ns / 1ps
`default_nettype none
`include "global_timer_64bit_compare_macros.svh"

module global_timer_64bit_compare (
    input  logic         clk,
    input  logic         rst_n,
    gt64c_req_if.sink    req,
    gt64c_rsp_if.source  rsp
);
    import gt64c_pkg::*;

    timer_state_t           state_reg;
    timer_state_t           state_next;
    logic                   out_valid_reg;
    logic [DataWidth-1:0]   rdata_reg;
    logic [DataWidth-1:0]   rdata_next;
    logic                   irq_reg;
    logic                   irq_next;
    logic                   accept;

    // request taken whenever the response slot is free or being drained
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    gt64c_step u_step (
        .cur     (state_reg),
        .cmd     (req.cmd),
        .reg_sel (req.reg_sel),
        .wdata   (req.wdata),
        .nxt     (state_next),
        .rdata   (rdata_next),
        .irq     (irq_next)
    );

    // timer state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.rdata = rdata_reg;
    assign rsp.irq   = irq_reg;

    // checks on the timer's own logic
    `GT_ASSERT_NOW(a_irq_tracks_state, clk, rst_n, out_valid_reg, irq_reg == (state_reg.flag && state_reg.ctl[CTL_IRQ_BIT]), "irq response disagrees with timer state")
    `GT_ASSERT_NEXT(a_status_clear, clk, rst_n, accept && (req.cmd == CMD_WRITE) && (req.reg_sel == REG_STATUS) && req.wdata[0], !state_reg.flag, "status write did not clear event flag")
    `GT_ASSERT_NEXT(a_nonread_zero, clk, rst_n, accept && (req.cmd != CMD_READ), rsp.rdata == 32'd0, "non-read transaction returned data")
    `GT_ASSERT_NEXT(a_disabled_hold, clk, rst_n, accept && (req.cmd == CMD_TICK) && !state_reg.ctl[CTL_ENABLE_BIT], $stable(state_reg), "disabled timer changed on tick")

endmodule

`default_nettype wire

// ===== tb/global_timer_64bit_compare_tb.sv =====
// self-checking testbench for the global timer with comparator and auto-increment
`timescale 1ns / 1ps

module global_timer_64bit_compare_tb;

    import gt64c_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // control bit masks
    localparam logic [3:0] CTL_EN   = 4'b1 << CTL_ENABLE_BIT;
    localparam logic [3:0] CTL_CMP  = 4'b1 << CTL_COMP_BIT;
    localparam logic [3:0] CTL_IRQ  = 4'b1 << CTL_IRQ_BIT;
    localparam logic [3:0] CTL_AUTO = 4'b1 << CTL_AUTOINC_BIT;

    localparam int DIR_ROWS   = 27;
    localparam int RAND_ITEMS = 1950;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
    } timer_rsp_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  sel;
        logic [31:0] data;
        logic        known;
        logic [31:0] rdata;
        logic        irq;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rsp_take = 1'b0;

    gt64c_req_if req_ch ();
    gt64c_rsp_if rsp_ch ();

    assign rsp_ch.ready = rsp_take;

    global_timer_64bit_compare dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    timer_state_t shadow;
    timer_rsp_t   pending_rsp [$];
    int           fail_count = 0;
    int           items_sent = 0;
    bit           idle_on = 1'b1;

    // directed transactions, expected result typed in only where obvious
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{CMD_READ,   REG_COUNT_LO, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_READ,   REG_CONTROL,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_READ,   REG_UNUSED,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_UNUSED, REG_UNUSED,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_TICK,   REG_COUNT_LO, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_WRITE,  REG_COUNT_LO, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_WRITE,  REG_COUNT_HI, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_READ,   REG_COUNT_HI, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{CMD_WRITE,  REG_AUTOINC,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_WRITE,  REG_CONTROL,  32'hFFFF_00FF, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_READ,   REG_CONTROL,  32'h0000_0000, 1'b1, 32'h0000_000F, 1'b0},
        // counter wraps onto the comparator
        '{CMD_TICK,   REG_COUNT_LO, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_READ,   REG_STATUS,   32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_READ,   REG_COMP_LO,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE,  REG_STATUS,   32'hFFFF_FFFE, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE,  REG_STATUS,   32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE,  REG_UNUSED,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        // largest prescaler, then shrink it below the running count
        '{CMD_WRITE,  REG_CONTROL,  32'h0000_FF03, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_TICK,   REG_COUNT_LO, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_TICK,   REG_COUNT_LO, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_TICK,   REG_COUNT_LO, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE,  REG_CONTROL,  32'h0000_0107, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_TICK,   REG_COUNT_LO, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        // comparator written equal to the counter raises nothing
        '{CMD_WRITE,  REG_COMP_HI,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE,  REG_COMP_LO,  32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_READ,   REG_STATUS,   32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_READ,   REG_COUNT_LO, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0}
    };

    always #5 clk = ~clk;

    // timer behaviour for one transaction, updates the shadow state
    function automatic timer_rsp_t timer_step(logic [1:0] c, logic [2:0] s, logic [31:0] d);
        timer_rsp_t r;
        r.rdata = '0;
        if (c == CMD_TICK) begin
            if (shadow.ctl[CTL_ENABLE_BIT]) begin
                if (shadow.pcount >= shadow.prescale) begin
                    shadow.pcount  = 8'd0;
                    shadow.counter = shadow.counter + 64'd1;
                    if (shadow.ctl[CTL_COMP_BIT] && shadow.counter == shadow.comparator)
                    begin
                        shadow.flag = 1'b1;
                        if (shadow.ctl[CTL_AUTOINC_BIT])
                            shadow.comparator = shadow.comparator + {32'd0, shadow.increment};
                    end
                end
                else
                begin
                    shadow.pcount = shadow.pcount + 8'd1;
                end
            end
        end
        else if (c == CMD_READ)
        begin
            case (s)
                REG_COUNT_LO: r.rdata = shadow.counter[31:0];
                REG_COUNT_HI: r.rdata = shadow.counter[63:32];
                REG_CONTROL:  r.rdata = {16'd0, shadow.prescale, 4'd0, shadow.ctl};
                REG_STATUS:   r.rdata = {31'd0, shadow.flag};
                REG_COMP_LO:  r.rdata = shadow.comparator[31:0];
                REG_COMP_HI:  r.rdata = shadow.comparator[63:32];
                REG_AUTOINC:  r.rdata = shadow.increment;
                default:      r.rdata = '0;
            endcase
        end
        else if (c == CMD_WRITE)
        begin
            case (s)
                REG_COUNT_LO: shadow.counter[31:0] = d;
                REG_COUNT_HI: shadow.counter[63:32] = d;
                REG_CONTROL:
                begin
                    shadow.ctl      = d[3:0];
                    shadow.prescale = d[PRESCALE_LSB +: 8];
                end
                REG_STATUS:   if (d[0]) shadow.flag = 1'b0;
                REG_COMP_LO:  shadow.comparator[31:0] = d;
                REG_COMP_HI:  shadow.comparator[63:32] = d;
                REG_AUTOINC:  shadow.increment = d;
                default:      ;
            endcase
        end
        r.irq = shadow.flag & shadow.ctl[CTL_IRQ_BIT];
        return r;
    endfunction

    // drive one request transaction and record its expected response
    task automatic send_item(input logic [1:0] c, input logic [2:0] s, input logic [31:0] d,
                             input logic known, input timer_rsp_t typed);
        timer_rsp_t predicted;
        while (idle_on && $urandom_range(99) < 10)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= c;
        req_ch.reg_sel <= s;
        req_ch.wdata   <= d;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = timer_step(c, s, d);
        pending_rsp.push_back(known ? typed : predicted);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] s, input logic [31:0] d);
        send_item(CMD_WRITE, s, d, 1'b0, '0);
    endtask

    // hold the request side until every response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // response checking and receiver stalls
    always @(posedge clk)
    begin : rsp_check
        timer_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected response: rdata %h irq %b", rsp_ch.rdata, rsp_ch.irq);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.rdata !== want.rdata) begin
                    $error("rdata: expected %h, got %h", want.rdata, rsp_ch.rdata);
                    fail_count++;
                end
                if (rsp_ch.irq !== want.irq) begin
                    $error("irq: expected %b, got %b", want.irq, rsp_ch.irq);
                    fail_count++;
                end
            end
        end
        rsp_take <= !(idle_on && $urandom_range(99) < 10);
    end

    initial
    begin : stimulus
        timer_rsp_t  typed;
        logic [63:0] target;
        logic [7:0]  prescale;
        logic [3:0]  ctl;
        int          seq_no;
        int          pick;

        seq_no = 0;
        shadow = '0;
        req_ch.valid   <= 1'b0;
        req_ch.cmd     <= CMD_TICK;
        req_ch.reg_sel <= REG_COUNT_LO;
        req_ch.wdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            typed.rdata = directed_rows[i].rdata;
            typed.irq   = directed_rows[i].irq;
            send_item(directed_rows[i].cmd, directed_rows[i].sel, directed_rows[i].data,
                      directed_rows[i].known, typed);
        end
        drain_responses();

        // random sequences: mostly set up a compare and tick through it
        while (items_sent < DIR_ROWS + RAND_ITEMS)
        begin
            seq_no++;
            idle_on = !(seq_no >= 30 && seq_no < 45);
            if (seq_no % 25 == 0)
                drain_responses();
            if ($urandom_range(99) < 15) begin
                // noise over the whole field space
                repeat ($urandom_range(20, 5))
                    send_item(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom(),
                              1'b0, '0);
            end
            else
            begin
                // occasionally park the counter just short of wrap
                if ($urandom_range(9) == 0) begin
                    write_reg(REG_COUNT_HI, 32'hFFFF_FFFF);
                    write_reg(REG_COUNT_LO, 32'hFFFF_FFFF - 32'($urandom_range(15)));
                end
                target = shadow.counter + 64'($urandom_range(12, 1));
                write_reg(REG_COMP_HI, target[63:32]);
                write_reg(REG_COMP_LO, target[31:0]);
                write_reg(REG_AUTOINC, ($urandom_range(3) == 0) ? $urandom()
                                                                : 32'($urandom_range(8)));
                prescale = ($urandom_range(19) == 0) ? 8'hFF : 8'($urandom_range(3));
                ctl = CTL_EN | CTL_CMP | (4'($urandom_range(15)) & (CTL_IRQ | CTL_AUTO));
                if ($urandom_range(9) == 0)
                    ctl = 4'($urandom_range(15));
                write_reg(REG_CONTROL, {16'($urandom()), prescale, 4'($urandom_range(15)), ctl});
                repeat ($urandom_range(40, 10))
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        send_item(CMD_TICK, 3'($urandom_range(7)), $urandom(), 1'b0, '0);
                    else if (pick < 85)
                        send_item(CMD_READ, 3'($urandom_range(7)), $urandom(), 1'b0, '0);
                    else if (pick < 95)
                        write_reg(REG_STATUS, $urandom());
                    else
                        // prescaler changed mid-count
                        write_reg(REG_CONTROL, {16'd0, 8'($urandom_range(3)), 4'd0, ctl});
                end
            end
        end
        idle_on = 1'b1;
        drain_responses();
        repeat (5) @(posedge clk);

        if (fail_count == 0)
            $display("global_timer_64bit_compare verification clean");
        else
            $display("global_timer_64bit_compare verification failed");
        $finish;
    end

    // overall time limit
    initial
    begin : watchdog
        #5_000_000;
        $display("global_timer_64bit_compare verification failed");
        $finish;
    end

endmodule
